### sv/bdq_pkg.sv
// Shared constants, types and codes for the bounded deque block.
// No dependencies; every other file but bdq_ram refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    // Sizing
    localparam int DEPTH       = 64;
    localparam int HANDLE_BITS = 32;

    // Fixed port field widths
    localparam int CMD_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;

    // Derived widths
    localparam int HW     = (HANDLE_BITS < VALUE_W) ? HANDLE_BITS : VALUE_W;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [HW-1:0]     t_handle;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [IDX_W:0]    t_idx_sum;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [CMP_W-1:0]  t_cmp;
    typedef logic [QPTR_W-1:0] t_qptr;
    typedef logic [QCNT_W-1:0] t_qcnt;

    localparam t_cnt     DEPTH_CNT = t_cnt'(DEPTH);
    localparam t_idx_sum DEPTH_SUM = t_idx_sum'(DEPTH);

    // Command codes on the input port
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK_BACK    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_PEEK_AT      = 4'd6;
    localparam logic [CMD_W-1:0] CMD_REMOVE_VALUE = 4'd7;
    localparam logic [CMD_W-1:0] CMD_REMOVE_AT    = 4'd8;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd3;

    // Decoded operation kinds
    typedef enum logic [3:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_PEEK_FRONT,
        OP_PEEK_BACK,
        OP_PEEK_AT,
        OP_REMOVE_VALUE,
        OP_REMOVE_AT,
        OP_NOP
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        t_handle            handle;
        logic [POS_W-1:0]   pos;
        logic               zero;   // handle is null
    } t_cmd;

endpackage

`default_nettype wire

### sv/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### sv/bdq_front.sv
// Front end: accepts input beats and decodes them into queue commands.
// Depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdq_front (
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [bdq_pkg::CMD_W-1:0]   i_command,
    input  wire logic [bdq_pkg::VALUE_W-1:0] i_value,
    input  wire logic [bdq_pkg::POS_W-1:0]   i_position,
    input  wire logic                        i_full,
    output logic                             o_push,
    output bdq_pkg::t_cmd                    o_cmd
);

    bdq_pkg::t_kind kind;

    always_comb begin
        unique case (i_command)
            bdq_pkg::CMD_PUSH_FRONT:   kind = bdq_pkg::OP_PUSH_FRONT;
            bdq_pkg::CMD_PUSH_BACK:    kind = bdq_pkg::OP_PUSH_BACK;
            bdq_pkg::CMD_POP_FRONT:    kind = bdq_pkg::OP_POP_FRONT;
            bdq_pkg::CMD_POP_BACK:     kind = bdq_pkg::OP_POP_BACK;
            bdq_pkg::CMD_PEEK_FRONT:   kind = bdq_pkg::OP_PEEK_FRONT;
            bdq_pkg::CMD_PEEK_BACK:    kind = bdq_pkg::OP_PEEK_BACK;
            bdq_pkg::CMD_PEEK_AT:      kind = bdq_pkg::OP_PEEK_AT;
            bdq_pkg::CMD_REMOVE_VALUE: kind = bdq_pkg::OP_REMOVE_VALUE;
            bdq_pkg::CMD_REMOVE_AT:    kind = bdq_pkg::OP_REMOVE_AT;
            default:                   kind = bdq_pkg::OP_NOP;
        endcase
    end

    always_comb begin
        o_cmd.kind   = kind;
        o_cmd.handle = bdq_pkg::t_handle'(i_value);
        o_cmd.pos    = i_position;
        o_cmd.zero   = (bdq_pkg::t_handle'(i_value) == '0);
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

`default_nettype wire

### sv/bdq_queue.sv
// Short command FIFO that decouples the front end from the back end.
// Depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdq_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bdq_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output bdq_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);

    bdq_pkg::t_cmd  r_mem [bdq_pkg::QDEPTH];
    bdq_pkg::t_qptr r_wr_ptr;
    bdq_pkg::t_qptr r_rd_ptr;
    bdq_pkg::t_qcnt r_fill;

    function automatic bdq_pkg::t_qptr ptr_inc(input bdq_pkg::t_qptr p);
        if (p == bdq_pkg::t_qptr'(bdq_pkg::QDEPTH - 1)) begin
            return '0;
        end
        return p + bdq_pkg::t_qptr'(1);
    endfunction

    assign o_full  = (r_fill == bdq_pkg::t_qcnt'(bdq_pkg::QDEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + bdq_pkg::t_qcnt'(1);
                2'b01:   r_fill <= r_fill - bdq_pkg::t_qcnt'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

### sv/bdq_back.sv
// Back end: deque state, entry RAM, command sequencer and result register.
// Depends on bdq_pkg and bdq_ram.
`timescale 1ns / 1ps
`default_nettype none

module bdq_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire bdq_pkg::t_cmd                 i_q_cmd,
    output logic                               o_q_pop,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [bdq_pkg::STATUS_W-1:0]       o_status,
    output logic [bdq_pkg::DATA_W-1:0]         o_data,
    output logic [bdq_pkg::COUNT_W-1:0]        o_count
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_TAKE  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;

    logic [2:0]       r_state, n_state;
    bdq_pkg::t_idx    r_head, n_head;
    bdq_pkg::t_cnt    r_count, n_count;
    bdq_pkg::t_kind   r_kind, n_kind;
    bdq_pkg::t_handle r_val, n_val;
    bdq_pkg::t_handle r_data, n_data;
    bdq_pkg::t_cnt    r_src, n_src;
    bdq_pkg::t_cnt    r_dst, n_dst;
    bdq_pkg::t_cnt    r_cmp_idx, n_cmp_idx;
    logic             r_wr_pend, n_wr_pend;
    logic             r_cmp_pend, n_cmp_pend;

    logic                          r_out_valid, n_out_valid;
    logic [bdq_pkg::STATUS_W-1:0]  r_out_status, n_out_status;
    bdq_pkg::t_handle              r_out_data, n_out_data;
    bdq_pkg::t_cnt                 r_out_count, n_out_count;

    logic                          ram_we;
    bdq_pkg::t_idx                 ram_waddr;
    bdq_pkg::t_handle              ram_wdata;
    bdq_pkg::t_idx                 ram_raddr;
    bdq_pkg::t_handle              rd_data;

    logic                          out_free;
    logic                          fin;
    logic [bdq_pkg::STATUS_W-1:0]  fin_status;
    bdq_pkg::t_handle              fin_data;
    logic                          pos_out;
    bdq_pkg::t_idx                 head_dec;
    bdq_pkg::t_idx                 last_idx;

    // Physical slot of logical index k
    function automatic bdq_pkg::t_idx slot(input bdq_pkg::t_idx h, input bdq_pkg::t_idx k);
        bdq_pkg::t_idx_sum s;
        s = {1'b0, h} + {1'b0, k};
        if (s >= bdq_pkg::DEPTH_SUM) begin
            s = s - bdq_pkg::DEPTH_SUM;
        end
        return s[bdq_pkg::IDX_W-1:0];
    endfunction

    bdq_ram #(
        .WIDTH (bdq_pkg::HW),
        .DEPTH (bdq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign pos_out  = (bdq_pkg::t_cmp'(i_q_cmd.pos) >= bdq_pkg::t_cmp'(r_count));
    assign head_dec = (r_head == '0) ? bdq_pkg::t_idx'(bdq_pkg::DEPTH - 1)
                                     : r_head - bdq_pkg::t_idx'(1);
    assign last_idx = bdq_pkg::t_idx'(r_count - bdq_pkg::t_cnt'(1));

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_kind     = r_kind;
        n_val      = r_val;
        n_data     = r_data;
        n_src      = r_src;
        n_dst      = r_dst;
        n_cmp_idx  = r_cmp_idx;
        n_wr_pend  = r_wr_pend;
        n_cmp_pend = r_cmp_pend;
        o_q_pop    = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_head;
        ram_wdata  = r_val;
        ram_raddr  = r_head;
        fin        = 1'b0;
        fin_status = bdq_pkg::ST_OK;
        fin_data   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    n_kind  = i_q_cmd.kind;
                    n_val   = i_q_cmd.handle;
                    unique case (i_q_cmd.kind) inside
                        bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
                            fin = 1'b1;
                            if (i_q_cmd.zero) begin
                                fin_status = bdq_pkg::ST_ZERO;
                            end else if (r_count == bdq_pkg::DEPTH_CNT) begin
                                fin_status = bdq_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = i_q_cmd.handle;
                                n_count   = r_count + bdq_pkg::t_cnt'(1);
                                if (i_q_cmd.kind == bdq_pkg::OP_PUSH_FRONT) begin
                                    ram_waddr = head_dec;
                                    n_head    = head_dec;
                                end else begin
                                    ram_waddr = slot(r_head, bdq_pkg::t_idx'(r_count));
                                end
                            end
                        end
                        bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_PEEK_FRONT: begin
                            if (r_count == '0) begin
                                fin        = 1'b1;
                                fin_status = bdq_pkg::ST_EMPTY;
                            end else begin
                                ram_raddr = r_head;
                                n_state   = S_READ;
                            end
                        end
                        bdq_pkg::OP_POP_BACK, bdq_pkg::OP_PEEK_BACK: begin
                            if (r_count == '0) begin
                                fin        = 1'b1;
                                fin_status = bdq_pkg::ST_EMPTY;
                            end else begin
                                ram_raddr = slot(r_head, last_idx);
                                n_state   = S_READ;
                            end
                        end
                        bdq_pkg::OP_PEEK_AT: begin
                            if (pos_out) begin
                                fin        = 1'b1;
                                fin_status = bdq_pkg::ST_EMPTY;
                            end else begin
                                ram_raddr = slot(r_head, bdq_pkg::t_idx'(i_q_cmd.pos));
                                n_state   = S_READ;
                            end
                        end
                        bdq_pkg::OP_REMOVE_AT: begin
                            if (pos_out) begin
                                fin        = 1'b1;
                                fin_status = bdq_pkg::ST_EMPTY;
                            end else begin
                                ram_raddr = slot(r_head, bdq_pkg::t_idx'(i_q_cmd.pos));
                                n_src     = bdq_pkg::t_cnt'(i_q_cmd.pos) + bdq_pkg::t_cnt'(1);
                                n_state   = S_TAKE;
                            end
                        end
                        bdq_pkg::OP_REMOVE_VALUE: begin
                            if (i_q_cmd.zero) begin
                                fin        = 1'b1;
                                fin_status = bdq_pkg::ST_ZERO;
                            end else if (r_count == '0) begin
                                fin        = 1'b1;
                                fin_status = bdq_pkg::ST_EMPTY;
                            end else begin
                                n_src      = '0;
                                n_cmp_pend = 1'b0;
                                n_state    = S_SCAN;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                fin      = 1'b1;
                fin_data = rd_data;
                n_state  = S_IDLE;
                case (r_kind)
                    bdq_pkg::OP_POP_FRONT: begin
                        n_count = r_count - bdq_pkg::t_cnt'(1);
                        n_head  = (r_count == bdq_pkg::t_cnt'(1)) ? '0
                                : slot(r_head, bdq_pkg::t_idx'(1));
                    end
                    bdq_pkg::OP_POP_BACK: begin
                        n_count = r_count - bdq_pkg::t_cnt'(1);
                        if (r_count == bdq_pkg::t_cnt'(1)) begin
                            n_head = '0;
                        end
                    end
                    default: begin
                        n_count = r_count;
                    end
                endcase
            end
            S_TAKE: begin
                n_data    = rd_data;
                n_wr_pend = 1'b0;
                n_state   = S_SHIFT;
            end
            S_SHIFT: begin
                // read entry src, write it one slot lower in the next cycle
                if (r_wr_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot(r_head, bdq_pkg::t_idx'(r_dst));
                    ram_wdata = rd_data;
                end
                if (r_src < r_count) begin
                    ram_raddr = slot(r_head, bdq_pkg::t_idx'(r_src));
                    n_wr_pend = 1'b1;
                    n_dst     = r_src - bdq_pkg::t_cnt'(1);
                    n_src     = r_src + bdq_pkg::t_cnt'(1);
                end else begin
                    n_wr_pend = 1'b0;
                    fin       = 1'b1;
                    fin_data  = r_data;
                    n_count   = r_count - bdq_pkg::t_cnt'(1);
                    if (r_count == bdq_pkg::t_cnt'(1)) begin
                        n_head = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_cmp_pend && (rd_data == r_val)) begin
                    n_data     = rd_data;
                    n_src      = r_cmp_idx + bdq_pkg::t_cnt'(1);
                    n_wr_pend  = 1'b0;
                    n_cmp_pend = 1'b0;
                    n_state    = S_SHIFT;
                end else if (r_src < r_count) begin
                    ram_raddr  = slot(r_head, bdq_pkg::t_idx'(r_src));
                    n_cmp_pend = 1'b1;
                    n_cmp_idx  = r_src;
                    n_src      = r_src + bdq_pkg::t_cnt'(1);
                end else if (r_cmp_pend) begin
                    n_cmp_pend = 1'b0;
                end else begin
                    fin        = 1'b1;
                    fin_status = bdq_pkg::ST_EMPTY;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_count  = r_out_count;
        if (fin) begin
            n_out_valid  = 1'b1;
            n_out_status = fin_status;
            n_out_data   = fin_data;
            n_out_count  = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_wr_pend   <= 1'b0;
            r_cmp_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_wr_pend   <= n_wr_pend;
            r_cmp_pend  <= n_cmp_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_val        <= n_val;
        r_data       <= n_data;
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_cmp_idx    <= n_cmp_idx;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_count  <= n_out_count;
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_data   = bdq_pkg::DATA_W'(r_out_data);
    assign o_count  = bdq_pkg::COUNT_W'(r_out_count);

endmodule

`default_nettype wire

### sv/bounded_deque_with_indexed_removal_unit.sv
// Top level of the bounded deque: front decoder, command queue, back end.
// Depends on bdq_pkg, bdq_front, bdq_queue, bdq_back (and bdq_ram below it).
//
// Usage
//   Input channel: i_valid / o_stall carry one command beat (i_command,
//   i_value, i_position). A beat is taken at a clock edge with i_valid high
//   and o_stall low. o_stall rises only when the two-deep command queue is
//   full, so the front keeps taking beats while the back works or waits.
//   Output channel: o_valid / i_stall carry one result beat per command
//   (o_status, o_data, o_count); it moves at an edge with o_valid high and
//   i_stall low. While i_stall is high the result register holds its beat
//   and the back end does not start the next command; the queue still fills.
//   With an idle back end, a push, a rejected command or an ignored code
//   is answered from S_IDLE; pop and peek pass through S_READ; remove_at
//   passes S_TAKE, then S_SHIFT over the entries behind position p;
//   remove_value walks S_SCAN, then S_SHIFT only if a match is found.
//   Throughput is set by the back end sequencer over the single-port-write,
//   single-port-read entry RAM: one entry read (scan) or moved (gap
//   close) per cycle. Pops at either end move the head or the count and
//   touch no other entry.
//   Reset (i_rst_n low, synchronous) empties the queue, clears head and
//   count and drops any pending result; the entry RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_indexed_removal_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [bdq_pkg::CMD_W-1:0]     i_command,
    input  wire logic [bdq_pkg::VALUE_W-1:0]   i_value,
    input  wire logic [bdq_pkg::POS_W-1:0]     i_position,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [bdq_pkg::STATUS_W-1:0]       o_status,
    output logic [bdq_pkg::DATA_W-1:0]         o_data,
    output logic [bdq_pkg::COUNT_W-1:0]        o_count
);

    // front -> queue
    logic          q_push;
    logic          q_full;
    bdq_pkg::t_cmd f_cmd;

    // queue -> back
    logic          q_valid;
    logic          q_pop;
    bdq_pkg::t_cmd q_cmd;

    bdq_front u_front (
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_command  (i_command),
        .i_value    (i_value),
        .i_position (i_position),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (f_cmd)
    );

    bdq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // Back end owns the deque state and the result register
    bdq_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_status  (o_status),
        .o_data    (o_data),
        .o_count   (o_count)
    );

endmodule

`default_nettype wire

### sv/bdq_checker.sv
// Port-level checks for the bounded deque top level, bound to it below.
// Depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdq_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic [bdq_pkg::CMD_W-1:0]     i_command,
    input wire logic [bdq_pkg::VALUE_W-1:0]   i_value,
    input wire logic [bdq_pkg::POS_W-1:0]     i_position,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic [bdq_pkg::STATUS_W-1:0]  o_status,
    input wire logic [bdq_pkg::DATA_W-1:0]    o_data,
    input wire logic [bdq_pkg::COUNT_W-1:0]   o_count
);

    // Command beat held by the sender while stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_command) && $stable(i_value)
                               && $stable(i_position))
        else $error("command beat changed while stalled");

    // Result beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_data)
                               && $stable(o_count))
        else $error("result beat changed while stalled");

    // No result beat right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Failed commands carry no handle
    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != bdq_pkg::ST_OK) |-> o_data == '0)
        else $error("nonzero data on failed command");

    // A dropped push is only reported at full depth
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == bdq_pkg::ST_FULL)
            |-> o_count == bdq_pkg::COUNT_W'(bdq_pkg::DEPTH))
        else $error("full status with count below depth");

endmodule

bind bounded_deque_with_indexed_removal_unit bdq_checker u_bdq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_command  (i_command),
    .i_value    (i_value),
    .i_position (i_position),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_status   (o_status),
    .o_data     (o_data),
    .o_count    (o_count)
);

`default_nettype wire

### tb/sv/bounded_deque_with_indexed_removal_unit_tb.sv
// Self-checking bench for the bounded deque: random and directed command beats
// are checked against a queue-based deque predictor. Needs bdq_pkg and the RTL.
`timescale 1ns / 1ps

module bounded_deque_with_indexed_removal_unit_tb;

    // Run shape
    localparam int RANDOM_BEATS  = 1425;          // plus ~25 directed beats
    localparam int POOL_SIZE     = 12;            // shared handles, so removals by value hit
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = bdq_pkg::DEPTH + 16; // a full remove_value walk plus margin
    localparam int TIMEOUT_NS    = 20_000_000;

    // Codes 9..15 have no meaning; the block answers ok with no change
    localparam logic [bdq_pkg::CMD_W-1:0] CMD_UNDEF_LO = 4'd9;
    localparam logic [bdq_pkg::CMD_W-1:0] CMD_UNDEF_HI = 4'd15;
    localparam logic [bdq_pkg::CMD_W-1:0] DRAIN_CMDS [4] =
        '{bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK,
          bdq_pkg::CMD_REMOVE_VALUE, bdq_pkg::CMD_REMOVE_AT};

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} t_fill_mode;

    typedef struct packed {
        logic [bdq_pkg::CMD_W-1:0]   command;
        logic [bdq_pkg::VALUE_W-1:0] value;
        logic [bdq_pkg::POS_W-1:0]   position;
    } t_cmd_beat;

    typedef struct packed {
        logic [bdq_pkg::STATUS_W-1:0] status;
        logic [bdq_pkg::DATA_W-1:0]   data;
        logic [bdq_pkg::COUNT_W-1:0]  count;
    } t_result_beat;

    // DUT ports; every input starts at a known value
    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_valid    = 1'b0;
    logic                         o_stall;
    logic [bdq_pkg::CMD_W-1:0]    i_command  = '0;
    logic [bdq_pkg::VALUE_W-1:0]  i_value    = '0;
    logic [bdq_pkg::POS_W-1:0]    i_position = '0;
    logic                         o_valid;
    logic                         i_stall    = 1'b0;
    logic [bdq_pkg::STATUS_W-1:0] o_status;
    logic [bdq_pkg::DATA_W-1:0]   o_data;
    logic [bdq_pkg::COUNT_W-1:0]  o_count;

    // Predictor state: front of the deque is index 0
    bdq_pkg::t_handle deque_shadow[$];
    t_cmd_beat        pending_beats[$];
    t_result_beat     expected_results[$];
    bdq_pkg::t_handle handle_pool [POOL_SIZE];

    int total_beats       = 0;
    int n_sent            = 0;
    int n_accepted        = 0;
    int n_results         = 0;
    int mismatch_count    = 0;
    int peak_fill         = 0;
    int n_full_drops      = 0;
    int n_value_hits      = 0;
    int sender_idle_pct   = 27;
    int receiver_idle_pct = 51;

    bounded_deque_with_indexed_removal_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_command  (i_command),
        .i_value    (i_value),
        .i_position (i_position),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_data     (o_data),
        .o_count    (o_count)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one command to the shadow deque and return the result it must give.
    // Zero-handle rejection is checked ahead of fullness on a push.
    function automatic t_result_beat deque_apply(input t_cmd_beat b);
        bdq_pkg::t_handle h;
        t_result_beat     r;
        int               hit;
        h        = bdq_pkg::t_handle'(b.value);
        r.status = bdq_pkg::ST_OK;
        r.data   = '0;
        hit      = -1;
        case (b.command)
            bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
                if (h == '0)
                    r.status = bdq_pkg::ST_ZERO;
                else if (deque_shadow.size() >= bdq_pkg::DEPTH)
                    r.status = bdq_pkg::ST_FULL;
                else if (b.command == bdq_pkg::CMD_PUSH_FRONT)
                    deque_shadow.push_front(h);
                else
                    deque_shadow.push_back(h);
            end
            bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK,
            bdq_pkg::CMD_PEEK_FRONT, bdq_pkg::CMD_PEEK_BACK: begin
                if (deque_shadow.size() == 0)
                    r.status = bdq_pkg::ST_EMPTY;
                else if (b.command == bdq_pkg::CMD_POP_FRONT)
                    r.data = bdq_pkg::DATA_W'(deque_shadow.pop_front());
                else if (b.command == bdq_pkg::CMD_POP_BACK)
                    r.data = bdq_pkg::DATA_W'(deque_shadow.pop_back());
                else if (b.command == bdq_pkg::CMD_PEEK_FRONT)
                    r.data = bdq_pkg::DATA_W'(deque_shadow[0]);
                else
                    r.data = bdq_pkg::DATA_W'(deque_shadow[deque_shadow.size() - 1]);
            end
            bdq_pkg::CMD_PEEK_AT, bdq_pkg::CMD_REMOVE_AT: begin
                if (int'(b.position) >= deque_shadow.size()) begin
                    r.status = bdq_pkg::ST_EMPTY;
                end else begin
                    r.data = bdq_pkg::DATA_W'(deque_shadow[b.position]);
                    if (b.command == bdq_pkg::CMD_REMOVE_AT)
                        deque_shadow.delete(int'(b.position));
                end
            end
            bdq_pkg::CMD_REMOVE_VALUE: begin
                if (h == '0) begin
                    r.status = bdq_pkg::ST_ZERO;
                end else begin
                    // first match from the front wins; order of the rest is kept
                    for (int i = 0; i < deque_shadow.size(); i++)
                        if (hit < 0 && deque_shadow[i] == h)
                            hit = i;
                    if (hit < 0) begin
                        r.status = bdq_pkg::ST_EMPTY;
                    end else begin
                        r.data = bdq_pkg::DATA_W'(deque_shadow[hit]);
                        deque_shadow.delete(hit);
                    end
                end
            end
            default: ;  // undefined codes: ok, no data, nothing changes
        endcase
        r.count = bdq_pkg::COUNT_W'(deque_shadow.size());
        return r;
    endfunction

    function automatic t_cmd_beat make_beat(input logic [bdq_pkg::CMD_W-1:0] c,
                                            input logic [bdq_pkg::VALUE_W-1:0] v,
                                            input logic [bdq_pkg::POS_W-1:0] p);
        t_cmd_beat b;
        b.command  = c;
        b.value    = v;
        b.position = p;
        return b;
    endfunction

    // Mostly pool handles so searches hit and duplicates appear, some
    // full-width random, a few null handles.
    function automatic logic [bdq_pkg::VALUE_W-1:0] pick_handle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 60)
            return bdq_pkg::VALUE_W'(handle_pool[$urandom_range(0, POOL_SIZE - 1)]);
        return $urandom;
    endfunction

    // Half near the front, half anywhere in the 6-bit range
    function automatic logic [bdq_pkg::POS_W-1:0] pick_position();
        if ($urandom_range(0, 1) != 0)
            return bdq_pkg::POS_W'($urandom_range(0, 7));
        return bdq_pkg::POS_W'($urandom_range(0, (1 << bdq_pkg::POS_W) - 1));
    endfunction

    function automatic logic [bdq_pkg::CMD_W-1:0] pick_command(input t_fill_mode mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return bdq_pkg::CMD_W'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
        if (mode == MODE_FILL && r < 85)
            return ($urandom_range(0, 1) != 0) ? bdq_pkg::CMD_PUSH_FRONT
                                               : bdq_pkg::CMD_PUSH_BACK;
        if (mode == MODE_DRAIN && r < 85)
            return DRAIN_CMDS[$urandom_range(0, 3)];
        return bdq_pkg::CMD_W'($urandom_range(bdq_pkg::CMD_PUSH_FRONT,
                                              bdq_pkg::CMD_REMOVE_AT));
    endfunction

    // Stimulus: directed corner cases first, then random segments that swing
    // the fill level between empty and full so every boundary gets exercised.
    initial begin : stimulus
        t_fill_mode mode;
        int         seg_left;
        handle_pool[0] = '1;
        handle_pool[1] = bdq_pkg::t_handle'(1);
        handle_pool[2] = bdq_pkg::t_handle'(32'h8000_0000);
        for (int i = 3; i < POOL_SIZE; i++) begin
            do handle_pool[i] = $urandom; while (handle_pool[i] == '0);
        end

        // empty deque: every read and removal reports empty
        pending_beats.push_back(make_beat(bdq_pkg::CMD_POP_FRONT,    32'h0000_0001, '0));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_POP_BACK,     32'h0000_0001, '0));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_PEEK_FRONT,   '0,            '0));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_PEEK_BACK,    '0,            '1));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_PEEK_AT,      '0,            '0));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_REMOVE_AT,    '0,            '0));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_REMOVE_VALUE, 32'h1234_5678, '0));
        // null handles rejected by push and by search
        pending_beats.push_back(make_beat(bdq_pkg::CMD_PUSH_FRONT,   '0,            '0));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_PUSH_BACK,    '0,            '1));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_REMOVE_VALUE, '0,            '0));
        // extreme handles at both ends
        pending_beats.push_back(make_beat(bdq_pkg::CMD_PUSH_BACK,    '1,            '0));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_PUSH_FRONT,   32'h0000_0001, '1));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_PUSH_BACK,    32'h8000_0000, '0));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_PUSH_FRONT,   32'h7FFF_FFFF, '0));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_PEEK_FRONT,   '0,            '0));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_PEEK_BACK,    '0,            '0));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_PEEK_AT,      '0,            6'd2));
        // index past the count leaves the deque alone; then a miss and a hit by value, remove at 1
        pending_beats.push_back(make_beat(bdq_pkg::CMD_PEEK_AT,      '0,            '1));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_REMOVE_AT,    '0,            '1));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_REMOVE_VALUE, 32'h5A5A_5A5A, '0));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_REMOVE_VALUE, '1,            '0));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_REMOVE_AT,    '0,            6'd1));
        // undefined codes with the other fields all set and all clear, then a pop_back
        pending_beats.push_back(make_beat(CMD_UNDEF_HI,              '1,            '1));
        pending_beats.push_back(make_beat(CMD_UNDEF_LO,              '0,            '0));
        pending_beats.push_back(make_beat(bdq_pkg::CMD_POP_BACK,     '0,            '0));

        mode     = MODE_FILL;
        seg_left = 0;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (seg_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       mode = MODE_FILL;
                    1:       mode = MODE_DRAIN;
                    default: mode = MODE_MIXED;
                endcase
                seg_left = $urandom_range(16, 80);
            end
            seg_left--;
            pending_beats.push_back(make_beat(pick_command(mode), pick_handle(),
                                              pick_position()));
        end
        total_beats = pending_beats.size();
    end

    // Driver: predicts each beat at the edge it is taken, then offers the next.
    // Idle split: receiver-heavy third, sender-heavy third, then no idling.
    always @(posedge i_clk) begin : drive
        t_cmd_beat    nb;
        t_result_beat want;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                want = deque_apply(make_beat(i_command, i_value, i_position));
                expected_results.push_back(want);
                n_accepted++;
                if (int'(want.count) > peak_fill)
                    peak_fill = int'(want.count);
                if (want.status == bdq_pkg::ST_FULL)
                    n_full_drops++;
                if (i_command == bdq_pkg::CMD_REMOVE_VALUE && want.status == bdq_pkg::ST_OK)
                    n_value_hits++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_beats.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct) begin
                    nb = pending_beats.pop_front();
                    i_valid    <= 1'b1;
                    i_command  <= nb.command;
                    i_value    <= nb.value;
                    i_position <= nb.position;
                    n_sent++;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (n_sent < total_beats / 3) begin
                sender_idle_pct   <= 27;
                receiver_idle_pct <= 51;
            end else if (n_sent < 2 * total_beats / 3) begin
                sender_idle_pct   <= 51;
                receiver_idle_pct <= 27;
            end else begin
                sender_idle_pct   <= 0;
                receiver_idle_pct <= 0;
            end
        end
    end

    task automatic flag_mismatch(input string what,
                                 input logic [bdq_pkg::DATA_W-1:0] want,
                                 input logic [bdq_pkg::DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] result %0d: %s expected 0x%0h got 0x%0h",
                     $realtime, n_results, what, want, got);
    endtask

    // Monitor: checks each result beat against the oldest prediction
    always @(posedge i_clk) begin : check
        t_result_beat want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    flag_mismatch("beat with no command pending, data", '0, o_data);
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status)
                        flag_mismatch("status", bdq_pkg::DATA_W'(want.status),
                                      bdq_pkg::DATA_W'(o_status));
                    if (o_data !== want.data)
                        flag_mismatch("data", want.data, o_data);
                    if (o_count !== want.count)
                        flag_mismatch("count", bdq_pkg::DATA_W'(want.count),
                                      bdq_pkg::DATA_W'(o_count));
                end
            end
            i_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    // Reset, then wait for every beat to be taken and answered
    initial begin : sequencer
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (pending_beats.size() != 0 || i_valid)
            @(negedge i_clk);
        while (expected_results.size() != 0)
            @(negedge i_clk);
        // a stray late beat would show up here
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Covered %0d command beats and %0d result beats; peak fill %0d of %0d.",
                 n_accepted, n_results, peak_fill, bdq_pkg::DEPTH);
        $display("Pushes dropped on full: %0d, value removals that hit: %0d, mismatches: %0d.",
                 n_full_drops, n_value_hits, mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hang guard
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timed out with %0d results still pending", expected_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
